// ===== rtl/atp_pkg.sv =====
// Shared constants, types and helper functions of the arc trajectory predictor.
// No dependencies; atp_cordic, atp_div and the top level import this package.
`default_nettype none

package atp_pkg;

  localparam int MAX_STEPS_DEF   = 20;
  localparam int CORDIC_ITER_DEF = 16;

  // fixed-point formats
  localparam int FRAC_BITS = 12;
  localparam int ANG_FRAC  = 30;
  localparam int ANG_SH    = ANG_FRAC - 2 * FRAC_BITS;
  localparam int DEN_SH    = ANG_FRAC - FRAC_BITS;

  localparam int IDX_W      = 6;
  localparam int CW         = 34;
  localparam int MAG_W      = 38;
  localparam int RED_STAGES = 5;
  localparam int QW         = 32;
  localparam int DEN_W      = 16;
  localparam int OFS_W      = 20;
  localparam int ATAN_COUNT = 24;

  localparam logic [MAG_W-1:0] TWO_PI_Q  = 38'd6746518852;
  localparam logic signed [35:0] PI_Q    = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_S = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q = 34'sd652032875;
  localparam logic signed [CW-1:0] ONE_Q  = 34'sd1073741824;

  localparam logic [15:0] STEP_RST    = 16'd1229;
  localparam logic [15:0] HORIZON_RST = 16'd12288;
  localparam logic signed [15:0] AXLE_RST = -16'sd1352;

  typedef enum logic [1:0] {
    REG_STEP    = 2'd0,
    REG_HORIZON = 2'd1,
    REG_AXLE    = 2'd2
  } reg_idx_t;

  // per-point data that travels alongside the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    last;
    logic                    straight;
    logic signed [15:0]      lin;
    logic signed [15:0]      ang;
    logic signed [15:0]      lat;
    logic signed [15:0]      axle;
    logic signed [23:0]      str_x;
    logic signed [23:0]      str_y;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic                    neg_x;
    logic                    neg_y;
  } side_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    logic signed [23:0] r;
    if (v > 36'sd8388607) r = 24'sd8388607;
    else if (v < -36'sd8388608) r = -24'sd8388608;
    else r = v[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atp_if.sv =====
// Valid/ready channel interfaces: command words in, path point words out.
// No dependencies.
`default_nettype none

interface atp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  logic signed [15:0] lateral_offset;
  modport source(output valid, linear_speed, turn_rate, lateral_offset, input ready);
  modport sink(input valid, linear_speed, turn_rate, lateral_offset, output ready);
endinterface

interface atp_point_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic [4:0]         point_index;
  logic               last_point;
  modport source(output valid, point_x, point_y, point_index, last_point, input ready);
  modport sink(input valid, point_x, point_y, point_index, last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/atp_cordic.sv =====
// Pipelined rotation-mode CORDIC, one iteration per stage, plus an output stage
// that applies the fold flag and the zero-heading bypass. Uses atp_pkg.
`default_nettype none

module atp_cordic #(
  parameter int ITER = atp_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [atp_pkg::CW-1:0] z_in,
  input  wire logic                         flip_in,
  input  wire logic                         zero_in,
  output logic signed [atp_pkg::CW-1:0]      sin_out,
  output logic signed [atp_pkg::CW-1:0]      cos_out
);
  import atp_pkg::*;

  logic signed [CW-1:0] xs [0:ITER-1];
  logic signed [CW-1:0] ys [0:ITER-1];
  logic signed [CW-1:0] zs [0:ITER-1];
  logic                 fl [0:ITER-1];
  logic                 zr [0:ITER-1];

  for (genvar j = 0; j < ITER; j++) begin : g_iter
    logic signed [CW-1:0] xi, yi, zi, at;
    logic                 fi, zri;
    if (j == 0) begin : g_first
      assign xi  = GAIN_Q;
      assign yi  = '0;
      assign zi  = z_in;
      assign fi  = flip_in;
      assign zri = zero_in;
    end else begin : g_next
      assign xi  = xs[j-1];
      assign yi  = ys[j-1];
      assign zi  = zs[j-1];
      assign fi  = fl[j-1];
      assign zri = zr[j-1];
    end
    assign at = $signed(CW'(atan_q30(j)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          xs[j] <= xi - (yi >>> j);
          ys[j] <= yi + (xi >>> j);
          zs[j] <= zi - at;
        end else begin
          xs[j] <= xi + (yi >>> j);
          ys[j] <= yi - (xi >>> j);
          zs[j] <= zi + at;
        end
        fl[j] <= fi;
        zr[j] <= zri;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zr[ITER-1]) begin
        sin_out <= '0;
        cos_out <= ONE_Q;
      end else begin
        sin_out <= ys[ITER-1];
        cos_out <= fl[ITER-1] ? -xs[ITER-1] : xs[ITER-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Uses atp_pkg for the divisor width.
`default_nettype none

module atp_div #(
  parameter int NW = atp_pkg::QW
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [NW-1:0]                 num_in,
  input  wire logic [atp_pkg::DEN_W-1:0]     den_in,
  output logic [NW-1:0]                      quo_out
);
  import atp_pkg::*;

  // quotient bits shift in from the bottom as numerator bits leave the top
  logic [DEN_W-1:0] rm [0:NW-1];
  logic [NW-1:0]    nm [0:NW-1];
  logic [DEN_W-1:0] dn [0:NW-1];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [DEN_W-1:0] ri, di;
    logic [NW-1:0]    ni;
    logic [DEN_W:0]   r;
    logic             ge;
    if (j == 0) begin : g_first
      assign ri = '0;
      assign ni = num_in;
      assign di = den_in;
    end else begin : g_next
      assign ri = rm[j-1];
      assign ni = nm[j-1];
      assign di = dn[j-1];
    end
    assign r  = {ri, ni[NW-1]};
    assign ge = r >= {1'b0, di};

    always_ff @(posedge clk) begin
      if (en) begin
        rm[j] <= ge ? DEN_W'(r - {1'b0, di}) : r[DEN_W-1:0];
        nm[j] <= {ni[NW-2:0], ge};
        dn[j] <= di;
      end
    end
  end

  assign quo_out = nm[NW-1];

endmodule

`default_nettype wire

// ===== rtl/arc_trajectory_predictor.sv =====
// Arc trajectory predictor top level: APB registers, step count divider, point
// sequencer and point pipeline. Uses atp_pkg, atp_if, atp_cordic and atp_div.
`default_nettype none

// Each accepted command word yields steps+1 point words, steps being
// max(1, round(horizon_time/step_time)) limited to MAX_STEPS. The point
// sequencer issues one point per cycle, while the output does not stall, into
// a fully pipelined datapath (heading multiply, modulo-2pi reduction,
// CORDIC_ITERATIONS CORDIC stages, products, a 32-stage pipelined divider,
// saturation), so a command occupies the input until its last point issues
// (2 to MAX_STEPS+1 points, so at most 21 with the default MAX_STEPS; 11 with
// the reset register values) and the next command is taken in the cycle its
// predecessor's last point issues. After reset and after every register write
// an 18-step serial divider recomputes the step count; cmd.ready stays low
// while it runs. Output back-pressure stalls the whole pipeline without losing
// or repeating a word.
module arc_trajectory_predictor #(
  parameter int MAX_STEPS         = atp_pkg::MAX_STEPS_DEF,
  parameter int CORDIC_ITERATIONS = atp_pkg::CORDIC_ITER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  atp_cmd_if.sink          cmd,
  atp_point_if.source      pts,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import atp_pkg::*;

  localparam int IW     = $clog2(MAX_STEPS + 1);
  localparam int TW     = IW + 16;
  localparam int SDIV_N = 18;
  localparam int ST_F   = 3 + RED_STAGES;
  localparam int ST_K   = ST_F + CORDIC_ITERATIONS + 1;
  localparam int ST_P   = ST_K + 1;
  localparam int ST_Q   = ST_P + 1;
  localparam int ST_D   = ST_Q + QW;
  localparam int ST_O   = ST_D + 1;

  // ---------------- registers ----------------
  logic [15:0]        step_time;
  logic [15:0]        horizon_time;
  logic signed [15:0] axle_offset;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time    <= STEP_RST;
      horizon_time <= HORIZON_RST;
      axle_offset  <= AXLE_RST;
    end else if (wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_STEP:    step_time    <= pwdata[15:0];
        REG_HORIZON: horizon_time <= pwdata[15:0];
        REG_AXLE:    axle_offset  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_STEP:    prdata = {16'd0, step_time};
      REG_HORIZON: prdata = {16'd0, horizon_time};
      REG_AXLE:    prdata = {16'd0, axle_offset};
      default:     prdata = '0;
    endcase
  end

  // ---------------- step count: (2h + st) / (2st) ----------------
  logic              sload;
  logic [4:0]        scnt;
  logic [16:0]       srem;
  logic [SDIV_N-1:0] snum;
  logic [16:0]       sden;
  logic [17:0]       strial;
  logic              sge;
  logic              sbusy;
  logic [IW-1:0]     steps;

  assign sden   = {step_time, 1'b0};
  assign strial = {srem, snum[SDIV_N-1]};
  assign sge    = strial >= {1'b0, sden};
  assign sbusy  = sload || (scnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sload <= 1'b1;
      scnt  <= '0;
    end else if (wr) begin
      sload <= 1'b1;
    end else if (sload) begin
      sload <= 1'b0;
      scnt  <= 5'(SDIV_N);
    end else if (scnt != '0) begin
      scnt <= scnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (sload) begin
      srem <= '0;
      snum <= SDIV_N'({horizon_time, 1'b0}) + SDIV_N'(step_time);
    end else if (scnt != '0) begin
      srem <= sge ? 17'(strial - {1'b0, sden}) : strial[16:0];
      snum <= {snum[SDIV_N-2:0], sge};
    end
  end

  always_comb begin
    priority if (step_time == '0) steps = IW'(MAX_STEPS);
    else if (snum == '0) steps = IW'(1);
    else if (snum > SDIV_N'(MAX_STEPS)) steps = IW'(MAX_STEPS);
    else steps = snum[IW-1:0];
  end

  // ---------------- point sequencer ----------------
  logic               en;
  logic               vld [0:ST_O];
  side_t              side [0:ST_O];
  side_t              side_in [1:ST_O];
  side_t              side0;

  logic               busy;
  logic [IW-1:0]      cnt;
  logic [TW-1:0]      tacc;
  logic signed [15:0] q_lin, q_ang, q_lat;
  logic               last_issue;
  logic               cmd_acc;
  logic [15:0]        tclamp;
  logic [15:0]        a_t;

  assign en         = !vld[ST_O] || pts.ready;
  assign last_issue = busy && (cnt == steps);
  assign cmd.ready  = en && !sbusy && (!busy || last_issue);
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign tclamp     = (tacc > TW'(horizon_time)) ? horizon_time : tacc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en) begin
      if (cmd_acc) busy <= 1'b1;
      else if (last_issue) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cmd_acc) begin
        q_lin <= cmd.linear_speed;
        q_ang <= cmd.turn_rate;
        q_lat <= cmd.lateral_offset;
        cnt   <= '0;
        tacc  <= '0;
      end else if (busy && !last_issue) begin
        cnt  <= cnt + IW'(1);
        tacc <= tacc + TW'(step_time);
      end
      a_t <= tclamp;
    end
  end

  always_comb begin
    side0          = '0;
    side0.idx      = IDX_W'(cnt);
    side0.last     = cnt == steps;
    side0.straight = q_ang == '0;
    side0.lin      = q_lin;
    side0.ang      = q_ang;
    side0.lat      = q_lat;
    side0.axle     = axle_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ST_O; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= busy;
      for (int k = 1; k <= ST_O; k++) vld[k] <= vld[k-1];
    end
  end

  // ---------------- stage B: heading and straight-line products ----------------
  logic signed [32:0] b_h2, b_sx;

  always_ff @(posedge clk) begin
    if (en) begin
      b_h2 <= side[0].ang * $signed({1'b0, a_t});
      b_sx <= side[0].lin * $signed({1'b0, a_t});
    end
  end

  // ---------------- stage C: Q.30 heading magnitude, straight result ----------------
  logic signed [38:0] hq;
  logic [MAG_W-1:0]   hq_mag;
  logic [32:0]        sx_mag;
  logic [33:0]        sx_rnd;
  logic signed [35:0] sx_q;

  assign hq     = 39'(b_h2) <<< ANG_SH;
  assign hq_mag = hq[38] ? MAG_W'(-hq) : MAG_W'(hq);
  assign sx_mag = b_sx[32] ? 33'(-b_sx) : 33'(b_sx);
  assign sx_rnd = (34'(sx_mag) + (34'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign sx_q   = b_sx[32] ? -$signed(36'(sx_rnd)) : $signed(36'(sx_rnd));

  // ---------------- modulo 2pi on the magnitude ----------------
  logic [MAG_W-1:0] red_mag  [0:RED_STAGES];
  logic             red_neg  [0:RED_STAGES];
  logic             red_zero [0:RED_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      red_mag[0]  <= hq_mag;
      red_neg[0]  <= hq[38];
      red_zero[0] <= hq == '0;
    end
  end

  for (genvar k = 0; k < RED_STAGES; k++) begin : g_red
    localparam logic [MAG_W-1:0] SUB = TWO_PI_Q << (RED_STAGES - 1 - k);
    always_ff @(posedge clk) begin
      if (en) begin
        red_mag[k+1]  <= (red_mag[k] >= SUB) ? red_mag[k] - SUB : red_mag[k];
        red_neg[k+1]  <= red_neg[k];
        red_zero[k+1] <= red_zero[k];
      end
    end
  end

  // ---------------- stage F: wrap to [-pi, pi], fold to [-pi/2, pi/2] ----------------
  logic signed [35:0]   rs, r1, rf;
  logic                 fold;
  logic signed [CW-1:0] f_z;
  logic                 f_flip, f_zero;

  always_comb begin
    rs = red_neg[RED_STAGES] ? -$signed(36'(red_mag[RED_STAGES]))
                             : $signed(36'(red_mag[RED_STAGES]));
    priority if (rs > PI_Q) r1 = rs - TWO_PI_S;
    else if (rs < -PI_Q) r1 = rs + TWO_PI_S;
    else r1 = rs;
    fold = 1'b1;
    priority if (r1 > HALF_PI_Q) rf = PI_Q - r1;
    else if (r1 < -HALF_PI_Q) rf = -PI_Q - r1;
    else begin
      rf   = r1;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_z    <= CW'(rf);
      f_flip <= fold;
      f_zero <= red_zero[RED_STAGES];
    end
  end

  // ---------------- CORDIC ----------------
  logic signed [CW-1:0] k_s, k_c;

  atp_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk     (clk),
    .en      (en),
    .z_in    (f_z),
    .flip_in (f_flip),
    .zero_in (f_zero),
    .sin_out (k_s),
    .cos_out (k_c)
  );

  // ---------------- stage P: products ----------------
  logic signed [CW:0]  onec;
  logic signed [49:0]  p_ls, p_ac, p_lats, p_as, p_latc;
  logic signed [50:0]  p_lc;

  assign onec = (CW+1)'(ONE_Q) - (CW+1)'(k_c);

  always_ff @(posedge clk) begin
    if (en) begin
      p_ls   <= side[ST_K].lin * k_s;
      p_lc   <= side[ST_K].lin * onec;
      p_ac   <= side[ST_K].axle * k_c;
      p_lats <= side[ST_K].lat * k_s;
      p_as   <= side[ST_K].axle * k_s;
      p_latc <= side[ST_K].lat * k_c;
    end
  end

  // ---------------- stage Q: offset rounding, divider operands ----------------
  function automatic logic signed [OFS_W-1:0] rnd30(input logic signed [50:0] v);
    logic [50:0] mg;
    logic [50:0] r;
    mg = v[50] ? 51'(-v) : 51'(v);
    r  = (mg + (51'd1 << (ANG_FRAC - 1))) >> ANG_FRAC;
    return v[50] ? -$signed(OFS_W'(r)) : $signed(OFS_W'(r));
  endfunction

  logic signed [50:0] vx, vy;
  logic [49:0]        mls;
  logic [50:0]        mlc;
  logic [DEN_W-1:0]   angm;
  logic [51:0]        nsx, nsy;
  logic [QW-1:0]      q_nx, q_ny;
  logic [DEN_W-1:0]   q_dv;

  assign vx   = 51'(p_ac) - 51'(p_lats);
  assign vy   = 51'(p_as) + 51'(p_latc);
  assign mls  = p_ls[49] ? 50'(-p_ls) : 50'(p_ls);
  assign mlc  = p_lc[50] ? 51'(-p_lc) : 51'(p_lc);
  assign angm = side[ST_P].ang[15] ? DEN_W'(-side[ST_P].ang) : DEN_W'(side[ST_P].ang);
  // half the divisor added so the floor division rounds half away from zero
  assign nsx  = 52'(mls) + (52'(angm) << (DEN_SH - 1));
  assign nsy  = 52'(mlc) + (52'(angm) << (DEN_SH - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      q_nx <= QW'(nsx >> DEN_SH);
      q_ny <= QW'(nsy >> DEN_SH);
      q_dv <= angm;
    end
  end

  // ---------------- side line ----------------
  always_comb begin
    for (int k = 1; k <= ST_O; k++) side_in[k] = side[k-1];
    side_in[2].str_x = sat24(sx_q + 36'(side[1].axle));
    side_in[2].str_y = 24'(side[1].lat);
    side_in[ST_Q].ox    = rnd30(vx);
    side_in[ST_Q].oy    = rnd30(vy);
    side_in[ST_Q].neg_x = p_ls[49] ^ side[ST_P].ang[15];
    side_in[ST_Q].neg_y = p_lc[50] ^ side[ST_P].ang[15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side0;
      for (int k = 1; k <= ST_O; k++) side[k] <= side_in[k];
    end
  end

  // ---------------- divider ----------------
  logic [QW-1:0] d_qx, d_qy;

  atp_div #(.NW(QW)) u_div_x (
    .clk     (clk),
    .en      (en),
    .num_in  (q_nx),
    .den_in  (q_dv),
    .quo_out (d_qx)
  );

  atp_div #(.NW(QW)) u_div_y (
    .clk     (clk),
    .en      (en),
    .num_in  (q_ny),
    .den_in  (q_dv),
    .quo_out (d_qy)
  );

  // ---------------- stage O: sum and saturate, or straight-line result ----------------
  logic signed [35:0] qsx, qsy;
  logic signed [23:0] o_x, o_y;

  assign qsx = side[ST_D].neg_x ? -$signed(36'(d_qx)) : $signed(36'(d_qx));
  assign qsy = side[ST_D].neg_y ? -$signed(36'(d_qy)) : $signed(36'(d_qy));

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[ST_D].straight) begin
        o_x <= side[ST_D].str_x;
        o_y <= side[ST_D].str_y;
      end else begin
        o_x <= sat24(qsx + 36'(side[ST_D].ox));
        o_y <= sat24(qsy + 36'(side[ST_D].oy));
      end
    end
  end

  assign pts.valid       = vld[ST_O];
  assign pts.point_x     = o_x;
  assign pts.point_y     = o_y;
  assign pts.point_index = side[ST_O].idx[4:0];
  assign pts.last_point  = side[ST_O].last;

  // ---------------- assertions ----------------
  a_seq_start: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> busy && (cnt == '0))
    else $error("sequencer did not start at point zero");

  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    sbusy |-> !cmd.ready)
    else $error("command taken while step count is recomputed");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    vld[ST_O] && side[ST_O].last |-> side[ST_O].idx <= IDX_W'(MAX_STEPS))
    else $error("last point beyond step limit");

endmodule

`default_nettype wire
